@@ hdl/assert_macros.svh @@
// assertion macros shared by the imu frame parser modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/imufp_pkg.sv @@
// shared types and constants of the imu register frame parser
// no dependencies; used by every module of the block
package imufp_pkg;

    localparam int FRAME_LEN = 29;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] FUNC_CODE  = 8'h03;
    localparam logic [7:0] COUNT_CODE = 8'h18;
    localparam logic [7:0] ADDR_RESET = 8'h50;

    localparam int ACC_W  = 16;
    localparam int RATE_W = 27;
    localparam int ANG_W  = 24;

    localparam logic signed [RATE_W-1:0] RATE_SCALE  = 27'sd2000;
    localparam logic signed [ANG_W-1:0]  ANGLE_SCALE = 24'sd180;

    // word slots in the payload, counted after the three header bytes
    localparam int WORD_ACC  = 0;
    localparam int WORD_RATE = 3;
    localparam int WORD_ANG  = 9;

    // result data width packed into whole bytes
    localparam int RES_BITS  = 3 * (ACC_W + RATE_W + ANG_W);
    localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;

    // byte 0 is the address byte of the frame
    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    typedef struct packed {
        logic                     frame_error;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic signed [ANG_W-1:0]  angle_x;
        logic signed [ANG_W-1:0]  angle_y;
        logic signed [ANG_W-1:0]  angle_z;
    } t_result;

    // big-endian signed word idx of the payload
    function automatic logic signed [ACC_W-1:0] word_at(input t_frame frame, input int idx);
        word_at = {frame[3 + 2 * idx], frame[4 + 2 * idx]};
    endfunction

endpackage

@@ hdl/imufp_frame_buf.sv @@
// byte shift line holding one 29-byte frame, fill count and frame-ready flag
// depends on imufp_pkg and assert_macros.svh
`include "assert_macros.svh"

module imufp_frame_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    output logic                  o_byte_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_slot_free,
    input  logic                  i_hdr_bad,
    output imufp_pkg::t_frame     o_frame,
    output logic                  o_eval
);

    localparam logic [imufp_pkg::CNT_W-1:0] LAST_CNT =
        imufp_pkg::CNT_W'(imufp_pkg::FRAME_LEN - 1);

    // r_sh[0] is the newest byte
    logic [imufp_pkg::FRAME_LEN-1:0][7:0] r_sh;
    logic [imufp_pkg::CNT_W-1:0]          r_count, n_count, w_base;
    logic                                 r_pend, n_pend;
    logic                                 w_accept;

    assign o_eval       = r_pend & i_slot_free;
    assign o_byte_ready = ~r_pend | i_slot_free;
    assign w_accept     = i_byte_valid & o_byte_ready;

    always_comb begin
        for (int k = 0; k < imufp_pkg::FRAME_LEN; k++) begin
            o_frame[k] = r_sh[imufp_pkg::FRAME_LEN-1-k];
        end
    end

    always_comb begin
        w_base = r_count;
        if (o_eval) begin
            // bad header keeps 28 bytes, the oldest falls off on the next shift
            w_base = i_hdr_bad ? LAST_CNT : '0;
        end
        n_count = w_base;
        n_pend  = r_pend & ~o_eval;
        if (w_accept) begin
            if (w_base == LAST_CNT) begin
                n_pend = 1'b1;
            end else begin
                n_count = w_base + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sh <= {r_sh[imufp_pkg::FRAME_LEN-2:0], i_byte};
        end
    end

    `CHK_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_count <= LAST_CNT,
        "fill count beyond frame length")
    `CHK_SAME(a_pend_cnt, i_clk, i_rst_n, r_pend, r_count == LAST_CNT,
        "full frame flagged with short count")
    `CHK_NEXT(a_pend_hold, i_clk, i_rst_n, r_pend && !o_eval, $stable(r_sh) && r_pend,
        "pending frame changed before evaluation")

endmodule

@@ hdl/imufp_decode.sv @@
// header check and word scaling of one held frame
// depends on imufp_pkg
module imufp_decode (
    input  imufp_pkg::t_frame  i_frame,
    input  logic [7:0]         i_dev_addr,
    output imufp_pkg::t_result o_result
);

    logic w_bad;
    logic signed [imufp_pkg::ACC_W-1:0]  w_word [9];
    logic signed [imufp_pkg::RATE_W-1:0] w_rate_ext [3];
    logic signed [imufp_pkg::ANG_W-1:0]  w_ang_ext [3];
    logic signed [imufp_pkg::RATE_W-1:0] w_rate [3];
    logic signed [imufp_pkg::ANG_W-1:0]  w_ang [3];

    assign w_bad = (i_frame[0] != i_dev_addr) || (i_frame[1] != imufp_pkg::FUNC_CODE) ||
                   (i_frame[2] != imufp_pkg::COUNT_CODE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_word[i]     = imufp_pkg::word_at(i_frame, imufp_pkg::WORD_ACC + i);
            w_word[3 + i] = imufp_pkg::word_at(i_frame, imufp_pkg::WORD_RATE + i);
            w_word[6 + i] = imufp_pkg::word_at(i_frame, imufp_pkg::WORD_ANG + i);
            w_rate_ext[i] = imufp_pkg::RATE_W'(w_word[3 + i]);
            w_ang_ext[i]  = imufp_pkg::ANG_W'(w_word[6 + i]);
            // products fit the field width exactly
            w_rate[i]     = w_rate_ext[i] * imufp_pkg::RATE_SCALE;
            w_ang[i]      = w_ang_ext[i] * imufp_pkg::ANGLE_SCALE;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.frame_error = w_bad;
        if (!w_bad) begin
            o_result.accel_x = w_word[0];
            o_result.accel_y = w_word[1];
            o_result.accel_z = w_word[2];
            o_result.rate_x  = w_rate[0];
            o_result.rate_y  = w_rate[1];
            o_result.rate_z  = w_rate[2];
            o_result.angle_x = w_ang[0];
            o_result.angle_y = w_ang[1];
            o_result.angle_z = w_ang[2];
        end
    end

endmodule

@@ hdl/imu_register_frame_parser_unit.sv @@
// channel   dir  handshake                          payload
// s_axis    in   s_axis_tvalid / s_axis_tready      tdata: rx_byte
// m_axis    out  m_axis_tvalid / m_axis_tready      tdata: decoded words, tuser: frame_error
// cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_data: device_address
//
// one byte per cycle unless input stalls; a frame's last byte is registered in the shift line first
// the frame check and the constant multiplies sit between the byte shift line and the
// result register; a full frame waits in the shift line only while the result register
// holds an untaken result, and then input stalls
// synchronous active-low reset clears the fill count and flags and sets the address to 0x50
// depends on imufp_pkg, imufp_frame_buf, imufp_decode and assert_macros.svh
`include "assert_macros.svh"

module imu_register_frame_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z, zeros
    output logic [imufp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,   // [0] frame_error
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_data      // device_address
);

    logic [7:0]           r_dev_addr;
    logic                 r_valid;
    imufp_pkg::t_result   r_res;
    imufp_pkg::t_result   w_res;
    imufp_pkg::t_frame    w_frame;
    logic                 w_slot_free;
    logic                 w_eval;

    assign o_cfg_ready = 1'b1;
    assign w_slot_free = ~r_valid | m_axis_tready;

    imufp_frame_buf u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_slot_free  (w_slot_free),
        .i_hdr_bad    (w_res.frame_error),
        .o_frame      (w_frame),
        .o_eval       (w_eval)
    );

    imufp_decode u_dec (
        .i_frame    (w_frame),
        .i_dev_addr (r_dev_addr),
        .o_result   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= imufp_pkg::ADDR_RESET;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dev_addr <= i_cfg_data;
            end
            if (w_eval) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.frame_error;
    assign m_axis_tdata  = {
        (imufp_pkg::TDATA_W - imufp_pkg::RES_BITS)'(0),
        r_res.angle_z, r_res.angle_y, r_res.angle_x,
        r_res.rate_z,  r_res.rate_y,  r_res.rate_x,
        r_res.accel_z, r_res.accel_y, r_res.accel_x
    };

    `CHK_NEXT(a_eval_shows, i_clk, i_rst_n, w_eval, m_axis_tvalid,
        "evaluated frame did not reach the result register")
    `CHK_SAME(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0,
        "frame error result carries nonzero data")
    `CHK_SAME(a_eval_slot, i_clk, i_rst_n, w_eval, !m_axis_tvalid || m_axis_tready,
        "result register overwritten while a result waits")

endmodule
